### hw/rtl/awrs_pkg.sv
// ============================================================================
// awrs_pkg
// Shared types and codes for the area-weighted rectangle splat block.
// ============================================================================
package awrs_pkg;

   localparam logic [1:0] FUNC_CLEAR   = 2'd0;
   localparam logic [1:0] FUNC_DEPOSIT = 2'd1;
   localparam logic [1:0] FUNC_READ    = 2'd2;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   localparam logic [2:0] REG_WINDOW_X_MIN = 3'd0;
   localparam logic [2:0] REG_WINDOW_Y_MIN = 3'd1;
   localparam logic [2:0] REG_PIXEL_WIDTH  = 3'd2;
   localparam logic [2:0] REG_PIXEL_HEIGHT = 3'd3;
   localparam logic [2:0] REG_RECIP_WIDTH  = 3'd4;
   localparam logic [2:0] REG_RECIP_HEIGHT = 3'd5;
   localparam logic [2:0] REG_GRID_ROWS    = 3'd6;
   localparam logic [2:0] REG_GRID_COLS    = 3'd7;

   localparam int CSR_AW = 5;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [31:0] center_x;
      logic signed [31:0] center_y;
      logic [30:0]        half_width;
      logic [30:0]        half_height;
      logic signed [31:0] cell_value;
      logic [15:0]        pixel_index;
   } req_type;

   typedef struct packed {
      logic signed [47:0] pixel_sum;
      logic               index_out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [31:0] window_x_min;
      logic [31:0] window_y_min;
      logic [30:0] pixel_width;
      logic [30:0] pixel_height;
      logic [30:0] recip_pixel_width;
      logic [30:0] recip_pixel_height;
      logic [8:0]  grid_rows;
      logic [8:0]  grid_cols;
   } cfg_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXTENT,
      ST_BOUNDS,
      ST_COORD_MUL,
      ST_COORD_SAVE,
      ST_ROW_POS,
      ST_ROW_OV,
      ST_ROW_FRAC,
      ST_COL_POS,
      ST_COL_OV,
      ST_COL_FRAC,
      ST_COL_AREA,
      ST_COL_PROD,
      ST_COL_WRITE,
      ST_RD_OUT
   } state_type;

endpackage

### hw/rtl/area_weighted_rect_splat_top.sv
// ============================================================================
// area_weighted_rect_splat_top
// Deposits rectangular cells onto a pixel image held in one store.
// ============================================================================
// One transaction is handled at a time. A read registers the store data and
// then registers the response, which waits while the output is stalled. A
// clear, and the clearing pass after reset, writes one store entry per cycle
// through all MAX_ROWS*MAX_COLS entries; no transaction is taken meanwhile. A
// deposit walks the covered rows and, per pixel touched, runs the store
// sequence of read, multiply, add and write back. A row or pixel without
// overlap is skipped, and a cell outside the window ends after the bounds check.
module area_weighted_rect_splat_top
   import awrs_pkg::*;
#(
   parameter int MAX_ROWS  = 256,
   parameter int MAX_COLS  = 256,
   parameter int ACC_WIDTH = 48
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);

   localparam int DEPTH    = MAX_ROWS * MAX_COLS;
   localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ROWS_CAP = (MAX_ROWS > 511) ? 511 : MAX_ROWS;
   localparam int COLS_CAP = (MAX_COLS > 511) ? 511 : MAX_COLS;
   localparam int SW       = ((ACC_WIDTH > 41) ? ACC_WIDTH : 41) + 1;
   localparam logic [SW-1:0] ACC_HI = {{(SW - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
   localparam logic [SW-1:0] ACC_LO = ~ACC_HI;

   cfg_type cfg;

   awrs_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   assign csr_pready = 1'b1;

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [ACC_WIDTH-1:0] mem_wr_data;
   logic                 mem_rd_en;
   logic [AW-1:0]        mem_rd_addr;
   logic [ACC_WIDTH-1:0] mem_rd_data;

   awrs_store #(
      .WIDTH (ACC_WIDTH),
      .DEPTH (DEPTH),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   state_type state_ff, state_in;

   logic [AW-1:0] clr_ptr_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;
   logic          oor_ff;

   logic [43:0] left_ff, right_ff, bot_ff, top_ff;
   logic [43:0] xmax_ff, ymax_ff;
   logic        vneg_ff;
   logic [31:0] mag_ff;
   logic [35:0] off_ff [4];
   logic [1:0]  k_ff;
   logic [50:0] pc_ff;
   logic [8:0]  c0_ff, c1_ff, r1_ff;
   logic [8:0]  i_ff, j_ff;
   logic [43:0] pos_ff;
   logic [30:0] ovc_ff;
   logic        ovneg_ff;
   logic [17:0] rowbase_ff;
   logic [16:0] fy_ff, fx_ff;
   logic [33:0] area_ff;
   logic [AW-1:0] addr_ff;
   logic [39:0] p_ff;

   logic [8:0]  rows_use, cols_use;
   logic [43:0] xmin_e, ymin_e;
   logic        accept, out_free, rd_oor;
   logic [17:0] grid_size;

   assign rows_use  = (cfg.grid_rows > 9'(ROWS_CAP)) ? 9'(ROWS_CAP) : cfg.grid_rows;
   assign cols_use  = (cfg.grid_cols > 9'(COLS_CAP)) ? 9'(COLS_CAP) : cfg.grid_cols;
   assign xmin_e    = {{12{cfg.window_x_min[31]}}, cfg.window_x_min};
   assign ymin_e    = {{12{cfg.window_y_min[31]}}, cfg.window_y_min};
   assign accept    = req_valid & req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;
   assign grid_size = 18'(rows_use) * 18'(cols_use);
   assign rd_oor    = {2'b00, req_data.pixel_index} >= grid_size;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared arithmetic for the coordinate, overlap, fraction, product and accumulate steps.
   logic [66:0] coord_prod;
   logic [35:0] coord_lo_raw;
   logic [35:0] coord_hi_raw;
   logic [51:0] coord_rnd;
   logic [8:0]  coord_cnt;
   logic [8:0]  coord_lo, coord_hi;
   logic [43:0] ov_lo, ov_hi, ov_lo_edge, ov_hi_edge, ov_diff, ov_size;
   logic [30:0] ov_clamped;
   logic [61:0] frac_prod;
   logic [45:0] frac_raw;
   logic [16:0] frac_sat;
   logic [30:0] frac_recip;
   logic [64:0] val_prod;
   logic [SW-1:0] add_c, add_s, add_sum;
   logic [ACC_WIDTH-1:0] add_res;
   logic signed [63:0] rd_ext;

   always_comb begin
      coord_prod   = 67'(off_ff[k_ff]) * 67'(k_ff[1] ? cfg.recip_pixel_height
                                                    : cfg.recip_pixel_width);
      coord_lo_raw = {1'b0, pc_ff[50:16]};
      coord_rnd    = {1'b0, pc_ff} + 52'hFFFF;
      coord_hi_raw = coord_rnd[51:16];
      coord_cnt    = k_ff[1] ? rows_use : cols_use;
      coord_lo     = (coord_lo_raw > 36'd511) ? 9'd511 : coord_lo_raw[8:0];
      coord_hi     = (coord_hi_raw > 36'(coord_cnt)) ? coord_cnt : coord_hi_raw[8:0];

      ov_lo      = (state_ff == ST_ROW_OV) ? bot_ff : left_ff;
      ov_hi      = (state_ff == ST_ROW_OV) ? top_ff : right_ff;
      ov_size    = (state_ff == ST_ROW_OV) ? 44'(cfg.pixel_height) : 44'(cfg.pixel_width);
      ov_hi_edge = ($signed(pos_ff + ov_size) < $signed(ov_hi)) ? pos_ff + ov_size : ov_hi;
      ov_lo_edge = ($signed(pos_ff) > $signed(ov_lo)) ? pos_ff : ov_lo;
      ov_diff    = ov_hi_edge - ov_lo_edge;
      ov_clamped = ($signed(ov_diff) > $signed(44'h0007FFFFFFF)) ? 31'h7FFFFFFF
                                                                 : ov_diff[30:0];

      frac_recip = (state_ff == ST_ROW_FRAC) ? cfg.recip_pixel_height
                                             : cfg.recip_pixel_width;
      frac_prod  = 62'(ovc_ff) * 62'(frac_recip);
      frac_raw   = frac_prod[61:16];
      frac_sat   = (frac_raw > 46'd65536) ? 17'd65536 : frac_raw[16:0];

      val_prod = 65'(mag_ff) * 65'(area_ff);

      add_c   = vneg_ff ? (~{{(SW - 40){1'b0}}, p_ff} + 1'b1) : {{(SW - 40){1'b0}}, p_ff};
      add_s   = {{(SW - ACC_WIDTH){mem_rd_data[ACC_WIDTH-1]}}, mem_rd_data};
      add_sum = add_s + add_c;
      if ($signed(add_sum) > $signed(ACC_HI)) begin
         add_res = ACC_HI[ACC_WIDTH-1:0];
      end else if ($signed(add_sum) < $signed(ACC_LO)) begin
         add_res = ACC_LO[ACC_WIDTH-1:0];
      end else begin
         add_res = add_sum[ACC_WIDTH-1:0];
      end

      rd_ext = 64'(signed'(mem_rd_data));
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ptr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (accept) begin
               case (req_data.func)
                  FUNC_CLEAR:   state_in = ST_CLEAR;
                  FUNC_DEPOSIT: state_in = ST_EXTENT;
                  FUNC_READ:    state_in = ST_RD_OUT;
                  default:      state_in = ST_IDLE;
               endcase
            end
         end
         ST_EXTENT: state_in = ST_BOUNDS;
         ST_BOUNDS: begin
            if (rows_use == 9'd0 || cols_use == 9'd0 ||
                $signed(right_ff) < $signed(xmin_e) || $signed(left_ff) > $signed(xmax_ff) ||
                $signed(top_ff) < $signed(ymin_e) || $signed(bot_ff) > $signed(ymax_ff)) begin
               state_in = ST_IDLE;
            end else begin
               state_in = ST_COORD_MUL;
            end
         end
         ST_COORD_MUL: state_in = ST_COORD_SAVE;
         ST_COORD_SAVE: state_in = (k_ff == 2'd3) ? ST_ROW_POS : ST_COORD_MUL;
         ST_ROW_POS: state_in = (i_ff >= r1_ff) ? ST_IDLE : ST_ROW_OV;
         ST_ROW_OV: state_in = ST_ROW_FRAC;
         ST_ROW_FRAC: state_in = ovneg_ff ? ST_ROW_POS : ST_COL_POS;
         ST_COL_POS: state_in = (j_ff >= c1_ff) ? ST_ROW_POS : ST_COL_OV;
         ST_COL_OV: state_in = ST_COL_FRAC;
         ST_COL_FRAC: state_in = ovneg_ff ? ST_COL_POS : ST_COL_AREA;
         ST_COL_AREA: state_in = ST_COL_PROD;
         ST_COL_PROD: state_in = ST_COL_WRITE;
         ST_COL_WRITE: state_in = ST_COL_POS;
         ST_RD_OUT: state_in = out_free ? ST_IDLE : ST_RD_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = addr_ff;
      mem_wr_data = add_res;
      mem_rd_en   = 1'b0;
      mem_rd_addr = AW'(32'(rowbase_ff) + 32'(j_ff));
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ptr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            mem_rd_en   = accept && req_data.func == FUNC_READ && !rd_oor;
            mem_rd_addr = AW'(32'(req_data.pixel_index));
         end
         ST_COL_AREA: mem_rd_en = 1'b1;
         ST_COL_WRITE: mem_wr_en = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) begin
            clr_ptr_ff <= clr_ptr_ff + 1'b1;
         end else begin
            clr_ptr_ff <= '0;
         end
         if (state_ff == ST_RD_OUT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            left_ff  <= {{12{req_data.center_x[31]}}, req_data.center_x}
                        - {13'd0, req_data.half_width};
            right_ff <= {{12{req_data.center_x[31]}}, req_data.center_x}
                        + {13'd0, req_data.half_width};
            bot_ff   <= {{12{req_data.center_y[31]}}, req_data.center_y}
                        - {13'd0, req_data.half_height};
            top_ff   <= {{12{req_data.center_y[31]}}, req_data.center_y}
                        + {13'd0, req_data.half_height};
            vneg_ff  <= req_data.cell_value[31];
            mag_ff   <= req_data.cell_value[31] ? (~req_data.cell_value + 32'd1)
                                                : req_data.cell_value;
            oor_ff   <= rd_oor;
         end
         ST_EXTENT: begin
            xmax_ff <= xmin_e + 44'(cols_use) * 44'(cfg.pixel_width);
            ymax_ff <= ymin_e + 44'(rows_use) * 44'(cfg.pixel_height);
         end
         ST_BOUNDS: begin
            off_ff[0] <= $signed(left_ff) < $signed(xmin_e) ? 36'd0 : 36'(left_ff - xmin_e);
            off_ff[1] <= $signed(right_ff) < $signed(xmin_e) ? 36'd0 : 36'(right_ff - xmin_e);
            off_ff[2] <= $signed(bot_ff) < $signed(ymin_e) ? 36'd0 : 36'(bot_ff - ymin_e);
            off_ff[3] <= $signed(top_ff) < $signed(ymin_e) ? 36'd0 : 36'(top_ff - ymin_e);
            k_ff      <= 2'd0;
         end
         ST_COORD_MUL: pc_ff <= coord_prod[66:16];
         ST_COORD_SAVE: begin
            case (k_ff)
               2'd0: c0_ff <= coord_lo;
               2'd1: c1_ff <= coord_hi;
               2'd2: i_ff  <= coord_lo;
               default: r1_ff <= coord_hi;
            endcase
            k_ff <= k_ff + 2'd1;
         end
         ST_ROW_POS: pos_ff <= 44'(cfg.pixel_height) * 44'(i_ff) + ymin_e;
         ST_ROW_OV: begin
            ovc_ff     <= ov_clamped;
            ovneg_ff   <= ov_diff[43];
            rowbase_ff <= 18'(i_ff) * 18'(cols_use);
         end
         ST_ROW_FRAC: begin
            fy_ff <= frac_sat;
            j_ff  <= c0_ff;
            if (ovneg_ff) i_ff <= i_ff + 9'd1;
         end
         ST_COL_POS: begin
            pos_ff <= 44'(cfg.pixel_width) * 44'(j_ff) + xmin_e;
            if (j_ff >= c1_ff) i_ff <= i_ff + 9'd1;
         end
         ST_COL_OV: begin
            ovc_ff   <= ov_clamped;
            ovneg_ff <= ov_diff[43];
         end
         ST_COL_FRAC: begin
            fx_ff <= frac_sat;
            if (ovneg_ff) j_ff <= j_ff + 9'd1;
         end
         ST_COL_AREA: begin
            area_ff <= 34'(fx_ff) * 34'(fy_ff);
            addr_ff <= mem_rd_addr;
         end
         ST_COL_PROD: p_ff <= val_prod[63:24];
         ST_COL_WRITE: j_ff <= j_ff + 9'd1;
         ST_RD_OUT: begin
            if (out_free) begin
               rsp_data_ff.pixel_sum          <= oor_ff ? 48'sd0 : rd_ext[47:0];
               rsp_data_ff.index_out_of_range <= oor_ff;
            end
         end
         default: ;
      endcase
   end

endmodule

### hw/rtl/awrs_csr.sv
// ============================================================================
// awrs_csr
// Configuration register file behind a simple APB-style port.
// ============================================================================
module awrs_csr
   import awrs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output cfg_type           cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_sel;

   assign wr_en   = psel & penable & pwrite;
   assign reg_sel = paddr[4:2];
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_x_min       <= 32'd0;
         cfg_ff.window_y_min       <= 32'd0;
         cfg_ff.pixel_width        <= 31'd65536;
         cfg_ff.pixel_height       <= 31'd65536;
         cfg_ff.recip_pixel_width  <= 31'd65536;
         cfg_ff.recip_pixel_height <= 31'd65536;
         cfg_ff.grid_rows          <= 9'd256;
         cfg_ff.grid_cols          <= 9'd256;
      end else if (wr_en) begin
         case (reg_sel)
            REG_WINDOW_X_MIN: cfg_ff.window_x_min       <= pwdata;
            REG_WINDOW_Y_MIN: cfg_ff.window_y_min       <= pwdata;
            REG_PIXEL_WIDTH:  cfg_ff.pixel_width        <= pwdata[30:0];
            REG_PIXEL_HEIGHT: cfg_ff.pixel_height       <= pwdata[30:0];
            REG_RECIP_WIDTH:  cfg_ff.recip_pixel_width  <= pwdata[30:0];
            REG_RECIP_HEIGHT: cfg_ff.recip_pixel_height <= pwdata[30:0];
            REG_GRID_ROWS:    cfg_ff.grid_rows          <= pwdata[8:0];
            REG_GRID_COLS:    cfg_ff.grid_cols          <= pwdata[8:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WINDOW_X_MIN: prdata = cfg_ff.window_x_min;
         REG_WINDOW_Y_MIN: prdata = cfg_ff.window_y_min;
         REG_PIXEL_WIDTH:  prdata = {1'b0, cfg_ff.pixel_width};
         REG_PIXEL_HEIGHT: prdata = {1'b0, cfg_ff.pixel_height};
         REG_RECIP_WIDTH:  prdata = {1'b0, cfg_ff.recip_pixel_width};
         REG_RECIP_HEIGHT: prdata = {1'b0, cfg_ff.recip_pixel_height};
         REG_GRID_ROWS:    prdata = {23'd0, cfg_ff.grid_rows};
         REG_GRID_COLS:    prdata = {23'd0, cfg_ff.grid_cols};
         default:          prdata = 32'd0;
      endcase
   end

endmodule

### hw/rtl/awrs_store.sv
// ============================================================================
// awrs_store
// Image store: one write port and one read port with registered read data.
// ============================================================================
module awrs_store #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536,
   parameter int AW    = 16
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule

### hw/rtl/awrs_checker.sv
// ============================================================================
// awrs_checker
// Port-level checks on the area-weighted rectangle splat block.
// ============================================================================
module awrs_checker
   import awrs_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("transaction taken during the clearing pass");

   a_busy_after_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_data.func == FUNC_CLEAR ||
       req_data.func == FUNC_DEPOSIT || req_data.func == FUNC_READ)) |=> !req_ready)
      else $error("transaction taken while the previous one is in progress");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.index_out_of_range) |-> rsp_data.pixel_sum == 48'sd0)
      else $error("out of range read returned a nonzero sum");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("result transaction dropped or changed while stalled");

endmodule

bind area_weighted_rect_splat_top awrs_checker u_awrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
